[design/twmv_pkg.sv]
// Shared types and constants for the time-weighted mean/variance unit.
// No dependencies.
package twmv_pkg;

    localparam int unsigned OP_ACCUM = 0;
    localparam int unsigned OP_RESET = 1;

    // Input request fields, highest bit first in tdata
    typedef struct packed {
        logic [31:0] sample_value;
        logic [9:0]  element_index;
        logic [31:0] sample_time;
    } t_in_data;

    typedef struct packed {
        logic [30:0] std_out;
        logic [31:0] mean_out;
        logic [9:0]  result_index;
    } t_out_data;

    // Operation codes for the shared divider / root unit
    typedef enum logic [1:0] {
        ALU_DIV = 2'd0,
        ALU_SQRT = 2'd1
    } t_alu_op;

    typedef struct packed {
        logic     start;
        t_alu_op  op;
    } t_alu_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_sts;

endpackage

[design/twmv_alu.sv]
// Shared bit-serial unit: 64/33 restoring divide or 64-bit integer root.
// Depends on twmv_pkg.
module twmv_alu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  twmv_pkg::t_alu_ctl  i_ctl,
    input  logic [63:0]         i_a,
    input  logic [32:0]         i_b,
    output twmv_pkg::t_alu_sts  o_sts,
    output logic [63:0]         o_res
);
    import twmv_pkg::*;

    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    t_alu_op     r_op, n_op;
    logic [63:0] r_q, n_q;
    logic [65:0] r_rem, n_rem;
    logic [63:0] r_x, n_x;
    logic [32:0] r_d, n_d;
    logic [65:0] trial;
    logic [65:0] rtry;

    always_comb begin
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_op = r_op;
        n_q = r_q;
        n_rem = r_rem;
        n_x = r_x;
        n_d = r_d;
        trial = '0;
        rtry = '0;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_op = i_ctl.op;
            n_x = i_a;
            n_d = i_b;
            n_q = '0;
            n_rem = '0;
            n_cnt = (i_ctl.op == ALU_DIV) ? 7'd64 : 7'd32;
        end else if (r_busy) begin
            if (r_op == ALU_DIV) begin
                // shift one dividend bit in, subtract if it fits
                trial = {r_rem[64:0], r_x[63]};
                n_x = {r_x[62:0], 1'b0};
                if (trial >= {33'd0, r_d}) begin
                    n_rem = trial - {33'd0, r_d};
                    n_q = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = trial;
                    n_q = {r_q[62:0], 1'b0};
                end
            end else begin
                // two radicand bits a step, trial root 4q+1
                trial = {r_rem[63:0], r_x[63:62]};
                n_x = {r_x[61:0], 2'b00};
                rtry = {r_q, 2'b01};
                if (trial >= rtry) begin
                    n_rem = trial - rtry;
                    n_q = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = trial;
                    n_q = {r_q[62:0], 1'b0};
                end
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_op <= n_op;
        r_q <= n_q;
        r_rem <= n_rem;
        r_x <= n_x;
        r_d <= n_d;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_res = r_q;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_ctl.start) else $error("alu restarted while busy");
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("alu done while busy");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == 7'd0) else $error("alu count left over");
endmodule

[design/time_weighted_mean_variance_unit.sv]
// Time-weighted running mean and standard deviation per element (weighted
// Welford), with a shared serial divide/root unit. An accumulate request
// runs, when weighted, at most a ratio divide, split multiplies, a variance
// divide and a root; when only reporting, at most the variance divide and
// the root; the block takes no request until its result has left. After
// reset and after each reset request while enabled, a clearing pass over
// all ELEMENTS entries runs before requests are taken.
module time_weighted_mean_variance_unit #(
    parameter int ELEMENTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // sample_time[31:0], element_index[41:32], sample_value[73:42]
    input  logic        s_axis_tuser,  // op
    input  logic        s_axis_tlast,  // last_of_frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // result_index[9:0], mean_out[41:10], std_out[72:42]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import twmv_pkg::*;

    localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int CW = $clog2(ELEMENTS + 1);

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_RDW = 4'd3,
        S_RATIO = 4'd4, S_MUL1 = 4'd5, S_MUL2 = 4'd6, S_MUL3 = 4'd7,
        S_ACC = 4'd8, S_VAR = 4'd9, S_SQRT = 4'd10, S_OUT = 4'd11, S_WAIT = 4'd12,
        S_HI = 4'd13, S_SUM = 4'd14;

    logic [3:0] r_st;
    logic [CW-1:0] r_clr;
    logic r_en;
    logic [31:0] r_el, r_prev;
    logic r_started;

    logic [31:0] r_mean_mem [ELEMENTS];
    logic [63:0] r_m2_mem [ELEMENTS];
    logic [31:0] r_mrd;
    logic [63:0] r_m2rd;

    logic [31:0] r_t, r_v, r_w, r_newel, r_nmean;
    logic [9:0]  r_idx;
    logic        r_last, r_valid;
    logic [63:0] r_ratio, r_dmag, r_q, r_m2, r_prod;
    logic        r_dneg;
    logic        r_vo;
    t_out_data   r_out;
    logic        r_mwe;
    t_alu_ctl    alu_ctl;
    t_alu_sts    alu_sts;
    logic [63:0] alu_a, alu_res;
    logic [32:0] alu_b;

    t_in_data in_d;
    assign in_d = s_axis_tdata[73:0];
    assign pready = 1'b1;
    assign prdata = {31'd0, r_en};
    wire cfg_wr = psel && penable && pwrite && pready && paddr == 2'd0;
    wire in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_st == S_IDLE) && !r_vo;
    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata = {7'd0, r_out};

    // combinational values from registered operands
    logic [32:0] delta_w;
    logic signed [32:0] delta;
    logic signed [32:0] nm;
    logic signed [32:0] e;
    logic [32:0] tot;
    logic [63:0] sum_el;
    logic [64:0] qw;
    assign delta = $signed({r_v[31], r_v}) - $signed({r_mrd[31], r_mrd});
    assign delta_w = delta;
    assign tot = {1'b0, r_el} + {1'b0, r_w};
    assign nm = r_dneg ? ($signed({r_mrd[31], r_mrd}) - $signed({1'b0, r_prod[63:32]}))
                       : ($signed({r_mrd[31], r_mrd}) + $signed({1'b0, r_prod[63:32]}));
    assign e = $signed({r_v[31], r_v}) - $signed({r_nmean[31], r_nmean});
    assign sum_el = {32'd0, r_el} + {32'd0, r_w};
    // q*w from the high and low partial products
    assign qw = {1'b0, r_ratio[31:0], 32'd0} + {1'b0, r_prod};

    logic [AW-1:0] ia;
    assign ia = r_idx[AW-1:0];
    logic neg;
    assign neg = (r_dneg != e[32]) && r_dmag != 64'd0 && e != 33'sd0;
    logic [63:0] add;
    logic [64:0] m2s;
    logic [63:0] m2n;
    always_comb begin
        // saturated product q*w, signed accumulate
        add = r_prod;
        m2n = r_m2rd;
        if (!neg) begin
            m2s = {r_m2rd[63], r_m2rd} + {1'b0, add};
            m2n = (m2s[64] != m2s[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : m2s[63:0];
        end else begin
            m2s = {r_m2rd[63], r_m2rd} - {1'b0, add};
            m2n = (m2s[64] != m2s[63]) ? 64'h8000_0000_0000_0000 : m2s[63:0];
        end
    end

    always_comb begin
        alu_ctl.start = 1'b0;
        alu_ctl.op = ALU_DIV;
        alu_a = '0;
        alu_b = '0;
        if (r_st == S_RDW && r_w != 32'd0 && r_valid) begin
            alu_ctl.start = 1'b1;
            alu_a = {r_w, 32'd0};
            alu_b = tot;
        end else if (r_st == S_VAR && r_newel != 32'd0 && r_valid
                     && !r_m2[63] && r_m2 != 64'd0) begin
            alu_ctl.start = 1'b1;
            alu_a = r_m2;
            alu_b = {1'b0, r_newel};
        end else if (r_st == S_SQRT && !alu_sts.busy && !alu_sts.done
                     && r_q[63:46] == 18'd0) begin
            alu_ctl.start = 1'b1;
            alu_ctl.op = ALU_SQRT;
            alu_a = {r_q[47:0], 16'd0};
        end
    end

    twmv_alu u_alu (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(alu_ctl), .i_a(alu_a),
        .i_b(alu_b), .o_sts(alu_sts), .o_res(alu_res));

    // store access: one write port, registered reads
    always_ff @(posedge i_clk) begin
        if (r_st == S_CLR) begin
            r_mean_mem[r_clr[AW-1:0]] <= '0;
            r_m2_mem[r_clr[AW-1:0]] <= '0;
        end else if (r_mwe) begin
            r_mean_mem[ia] <= r_nmean;
            r_m2_mem[ia] <= r_m2;
        end
        r_mrd <= r_mean_mem[ia];
        r_m2rd <= r_m2_mem[ia];
    end

    always_ff @(posedge i_clk) begin
        r_mwe <= (r_st == S_WAIT);
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_clr <= '0;
            r_en <= 1'b0;
            r_el <= '0;
            r_prev <= '0;
            r_started <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (cfg_wr) r_en <= pwdata[0];
            if (r_vo && m_axis_tready) r_vo <= 1'b0;
            case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CW'(ELEMENTS - 1)) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_t <= in_d.sample_time;
                        r_idx <= in_d.element_index;
                        r_v <= in_d.sample_value;
                        r_last <= s_axis_tlast;
                        r_valid <= {22'd0, in_d.element_index} < 32'(ELEMENTS);
                        r_w <= (r_started && in_d.sample_time > r_prev)
                               ? in_d.sample_time - r_prev : 32'd0;
                        if (s_axis_tuser == 1'(OP_RESET)) begin
                            if (r_en) begin
                                r_el <= '0;
                                r_prev <= in_d.sample_time;
                                r_started <= 1'b1;
                                r_clr <= '0;
                                r_st <= S_CLR;
                            end
                        end else if (!r_en) begin
                            r_out <= '{std_out: '0, mean_out: in_d.sample_value,
                                       result_index: in_d.element_index};
                            r_vo <= 1'b1;
                        end else begin
                            r_st <= S_RD;
                        end
                    end
                end
                S_RD: r_st <= S_RDW;
                S_RDW: begin
                    r_newel <= (r_w == 32'd0) ? r_el
                               : (sum_el[32] ? 32'hFFFF_FFFF : sum_el[31:0]);
                    r_dneg <= delta[32];
                    r_dmag <= {31'd0, delta[32] ? 33'(-delta_w) : delta_w};
                    r_nmean <= r_mrd;
                    r_m2 <= r_m2rd;
                    r_st <= (r_w != 32'd0 && r_valid) ? S_RATIO : S_VAR;
                end
                S_RATIO: if (alu_sts.done) begin
                    r_ratio <= alu_res;
                    r_st <= S_MUL1;
                end
                S_MUL1: begin
                    r_prod <= r_dmag[31:0] * r_ratio[31:0]
                              + (r_dmag[32] ? {r_ratio[31:0], 32'd0} : 64'd0)
                              + (r_ratio[32] ? {r_dmag[31:0], 32'd0} : 64'd0);
                    r_st <= S_MUL2;
                end
                S_MUL2: begin
                    r_nmean <= nm[31:0];
                    r_st <= S_MUL3;
                end
                S_MUL3: begin
                    r_prod <= r_dmag[32:0] * (e[32] ? 33'(-e) : 33'(e));
                    r_st <= S_ACC;
                end
                S_ACC: begin
                    // q is 48 bits: low partial product of q*w first
                    r_q <= {16'd0, r_prod[63:16]};
                    r_prod <= r_prod[47:16] * r_w;
                    r_st <= S_HI;
                end
                S_HI: begin
                    r_ratio <= r_q[47:32] * r_w;
                    r_st <= S_SUM;
                end
                S_SUM: begin
                    r_prod <= (r_ratio[47:31] != 17'd0 || qw[64:63] != 2'd0)
                              ? 64'h7FFF_FFFF_FFFF_FFFF : qw[63:0];
                    r_st <= S_WAIT;
                end
                S_WAIT: begin
                    r_m2 <= m2n;
                    r_st <= S_VAR;
                end
                S_VAR: begin
                    r_q <= '0;
                    if (r_newel == 32'd0 || !r_valid) begin
                        r_out <= '{std_out: '0, mean_out: r_v, result_index: r_idx};
                        r_st <= S_OUT;
                    end else if (r_m2[63] || r_m2 == 64'd0) begin
                        r_out <= '{std_out: '0, mean_out: r_nmean, result_index: r_idx};
                        r_st <= S_OUT;
                    end else begin
                        r_st <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (alu_sts.done && r_q == 64'd0) begin
                        if (alu_res[63:46] != 18'd0) begin
                            r_out <= '{std_out: 31'h7FFF_FFFF, mean_out: r_nmean,
                                       result_index: r_idx};
                            r_st <= S_OUT;
                        end else if (alu_res == 64'd0) begin
                            r_out <= '{std_out: '0, mean_out: r_nmean,
                                       result_index: r_idx};
                            r_st <= S_OUT;
                        end else begin
                            r_q <= alu_res;
                        end
                    end else if (alu_sts.done) begin
                        r_out <= '{std_out: alu_res[30:0], mean_out: r_nmean,
                                   result_index: r_idx};
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_vo) begin
                        r_vo <= 1'b1;
                        if (r_last) begin
                            r_prev <= r_t;
                            r_el <= r_newel;
                            r_started <= 1'b1;
                        end
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_st == S_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && !m_axis_tready |=> r_vo) else $error("result dropped");
    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_CLR |-> !alu_ctl.start) else $error("alu used while clearing");
endmodule

[sim/tb.sv]
// Testbench for time_weighted_mean_variance_unit: random and directed stream requests,
// checked against a built-in weighted Welford predictor. Depends on twmv_pkg.
module tb;
    import twmv_pkg::*;

    localparam int N_ELEM = 1024;
    localparam int WATCHDOG = 200000;

    typedef struct {
        bit          op;
        bit [31:0]   t;
        bit [9:0]    idx;
        bit [31:0]   val;
        bit          last;
    } req_t;

    typedef struct {
        bit [9:0]  idx;
        bit [31:0] mean;
        bit [30:0] sd;
    } stat_t;

    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready, s_axis_tuser, s_axis_tlast;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        psel, penable, pwrite, pready;
    logic [1:0]  paddr;
    logic [31:0] pwdata, prdata;

    time_weighted_mean_variance_unit #(.ELEMENTS(N_ELEM)) u_top (.*);

    // predictor state
    bit signed [31:0] p_mean [N_ELEM];
    bit signed [63:0] p_m2 [N_ELEM];
    bit [31:0] p_elapsed, p_prev;
    bit        p_started, p_enabled;

    req_t  pending_q[$];
    stat_t expected_q[$];
    int    errors, idle_cycles;
    bit    hold_off;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit [63:0] isqrt(bit [63:0] x);
        bit [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void weigh_element(int i, longint v, bit [31:0] w);
        longint mn, d, nm, e, m2;
        bit [63:0] dm, em, ratio, inc, q, add, tot;
        bit neg;
        mn = p_mean[i];
        d = v - mn;
        dm = d < 0 ? -d : d;
        tot = 64'(p_elapsed) + 64'(w);
        ratio = (64'(w) << 32) / tot;
        inc = 64'((128'(dm) * 128'(ratio)) >> 32);
        nm = d < 0 ? mn - longint'(inc) : mn + longint'(inc);
        e = v - nm;
        em = e < 0 ? -e : e;
        q = 64'((128'(dm) * 128'(em)) >> 16);
        neg = ((d < 0) != (e < 0)) && d != 0 && e != 0;
        m2 = p_m2[i];
        p_mean[i] = 32'(nm);
        if (q > 64'h7FFF_FFFF_FFFF_FFFF / 64'(w)) add = 64'h7FFF_FFFF_FFFF_FFFF;
        else add = q * 64'(w);
        if (!neg) begin
            if (m2 > 64'sh7FFF_FFFF_FFFF_FFFF - longint'(add)) m2 = 64'sh7FFF_FFFF_FFFF_FFFF;
            else m2 += longint'(add);
        end else begin
            if (m2 < longint'(64'h8000_0000_0000_0000) + longint'(add))
                m2 = longint'(64'h8000_0000_0000_0000);
            else m2 -= longint'(add);
        end
        p_m2[i] = m2;
    endfunction

    function automatic void predict_stats(req_t r);
        bit [31:0] w, nel;
        stat_t s;
        bit [63:0] var_q;
        longint v;
        v = longint'($signed(r.val));
        if (r.op == 1'b1) begin
            if (p_enabled) begin
                foreach (p_mean[i]) begin
                    p_mean[i] = 0;
                    p_m2[i] = 0;
                end
                p_elapsed = 0;
                p_prev = r.t;
                p_started = 1;
            end
            return;
        end
        s.idx = r.idx;
        s.mean = r.val;
        s.sd = 0;
        if (p_enabled) begin
            w = (p_started && r.t > p_prev) ? r.t - p_prev : 0;
            nel = p_elapsed;
            if (w != 0) begin
                weigh_element(int'(r.idx), v, w);
                nel = (33'(p_elapsed) + 33'(w) > 33'h0FFFF_FFFF) ? 32'hFFFF_FFFF
                                                              : p_elapsed + w;
            end
            if (nel != 0) begin
                s.mean = p_mean[r.idx];
                if (p_m2[r.idx] > 0) begin
                    var_q = 64'(p_m2[r.idx]) / 64'(nel);
                    if (var_q >= (64'd1 << 46)) s.sd = 31'h7FFF_FFFF;
                    else s.sd = 31'(isqrt(var_q << 16));
                end
            end
            if (r.last) begin
                p_prev = r.t;
                p_elapsed = nel;
                p_started = 1;
            end
        end
        expected_q.push_back(s);
    endfunction

    task automatic report(string what, bit [63:0] got, bit [63:0] want);
        errors++;
        $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    // driver
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
            s_axis_tdata <= 0;
            s_axis_tuser <= 0;
            s_axis_tlast <= 0;
            send_gap <= 0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
        end else if (send_gap > 0) begin
            s_axis_tvalid <= 0;
            send_gap <= send_gap - 1;
        end else if (pending_q.size() > 0) begin
            req_t r;
            r = pending_q.pop_front();
            predict_stats(r);
            s_axis_tvalid <= 1;
            s_axis_tdata <= {6'd0, r.val, r.idx, r.t};
            s_axis_tuser <= r.op;
            s_axis_tlast <= r.last;
            send_gap <= $urandom_range(0, 7);
        end else begin
            s_axis_tvalid <= 0;
        end
    end

    // monitor
    int recv_gap;
    always @(posedge i_clk) begin
        int g;
        if (!i_rst_n) begin
            m_axis_tready <= 0;
            recv_gap <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                stat_t e;
                if (expected_q.size() == 0) begin
                    report("unexpected result", m_axis_tdata[63:0], 64'd0);
                end else begin
                    e = expected_q.pop_front();
                    if (m_axis_tdata[9:0] != e.idx)
                        report("result_index", 64'(m_axis_tdata[9:0]), 64'(e.idx));
                    if (m_axis_tdata[41:10] != e.mean)
                        report("mean_out", 64'(m_axis_tdata[41:10]), 64'(e.mean));
                    if (m_axis_tdata[72:42] != e.sd)
                        report("std_out", 64'(m_axis_tdata[72:42]), 64'(e.sd));
                end
            end
            if (hold_off) begin
                m_axis_tready <= 0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                g = $urandom_range(0, 7);
                recv_gap <= g;
                m_axis_tready <= (g == 0);
            end else if (recv_gap == 0) begin
                m_axis_tready <= 1;
            end else begin
                recv_gap <= recv_gap - 1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
            idle_cycles <= 0;
        else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("FAIL time_weighted_mean_variance_unit");
                $finish;
            end
        end
    end

    task automatic apb_write(bit [31:0] data);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 0; pwdata <= data;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        p_enabled = data[0];
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || expected_q.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (1500) @(posedge i_clk);
    endtask

    task automatic push_req(bit op, bit [31:0] t, bit [9:0] idx, bit [31:0] val, bit last);
        req_t r;
        r.op = op; r.t = t; r.idx = idx; r.val = val; r.last = last;
        pending_q.push_back(r);
    endtask

    // frames of a few elements with mostly advancing time, plus noise and resets
    task automatic random_phase(int count, bit [31:0] t0);
        bit [31:0] t;
        int k, n, sel;
        t = t0;
        k = 0;
        while (k < count) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                push_req(1, t, 10'($urandom), $urandom, 1'($urandom));
                k++;
            end else begin
                n = $urandom_range(1, 6);
                for (int j = 0; j < n; j++) begin
                    bit [31:0] val;
                    val = (sel < 4) ? $urandom : 32'($signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000);
                    push_req(0, t, (sel == 1) ? 10'($urandom) : 10'($urandom_range(0, 7)),
                             val, j == n - 1);
                    k++;
                end
                if (sel == 2) t = t - $urandom_range(0, 5);
                else if (sel == 3) t = t + $urandom;
                else t = t + $urandom_range(1, 300);
            end
        end
    endtask

    initial begin
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        hold_off = 0;
        p_elapsed = 0; p_prev = 0; p_started = 0; p_enabled = 0;
        foreach (p_mean[i]) begin
            p_mean[i] = 0;
            p_m2[i] = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (N_ELEM + 20) @(posedge i_clk);

        // pass-through while disabled; reset request is ignored
        push_req(0, 32'hFFFF_FFFF, 10'h3FF, 32'h8000_0000, 1);
        push_req(1, 32'd5, 10'd0, 32'h7FFF_FFFF, 0);
        push_req(0, 32'd0, 10'd0, 32'h7FFF_FFFF, 0);
        wait_drained();

        apb_write(1);
        // first frame, then weighted frames, extreme values, non-positive dt
        push_req(0, 32'd10, 10'd0, 32'h0001_0000, 0);
        push_req(0, 32'd10, 10'd1023, 32'h8000_0000, 1);
        push_req(0, 32'd20, 10'd0, 32'h7FFF_FFFF, 0);
        push_req(0, 32'd20, 10'd1023, 32'h7FFF_FFFF, 1);
        push_req(0, 32'd20, 10'd0, 32'h8000_0000, 1);
        push_req(0, 32'd15, 10'd1, 32'h0000_0000, 1);
        push_req(0, 32'hFFFF_FFFF, 10'd0, 32'h8000_0000, 0);
        push_req(0, 32'hFFFF_FFFF, 10'd1023, 32'h0000_8000, 1);
        push_req(1, 32'd100, 10'd0, 32'd0, 1);
        push_req(0, 32'd150, 10'd2, 32'hFFFF_0000, 1);
        push_req(0, 32'd151, 10'd2, 32'h0002_0000, 1);
        wait_drained();

        random_phase(300, 32'd1000);
        // long hold-off so the block backs up
        hold_off <= 1;
        random_phase(20, 32'h1000_0000);
        repeat (3000) @(posedge i_clk);
        hold_off <= 0;
        wait_drained();

        apb_write(0);
        random_phase(150, 32'h2000_0000);
        wait_drained();
        apb_write(1);
        random_phase(400, 32'h3000_0000);
        wait_drained();

        if (errors == 0) begin
            $display("PASS time_weighted_mean_variance_unit");
        end else begin
            $display("FAIL time_weighted_mean_variance_unit");
        end
        $finish;
    end
endmodule

[files.f]
design/twmv_pkg.sv
design/twmv_alu.sv
design/time_weighted_mean_variance_unit.sv
sim/tb.sv
